>>> hw/rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// shared constants, types and helpers for the three stack shared buffer
// ----------------------------------------------------------------------------
package tsb_pkg;

   localparam int DEPTH      = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IO_WIDTH   = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int PTR_W      = $clog2(DEPTH + 1);

   localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_HALF  = PTR_W'(DEPTH / 2);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ID_LEFT  = 2'd0,
      ID_MID   = 2'd1,
      ID_RIGHT = 2'd2,
      ID_BAD   = 2'd3
   } stack_id_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BADID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_MOVE_RD,
      S_MOVE_WR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic start_move;
      logic move_rd;
      logic move_wr;
      logic move_end;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic collide;
      logic blocked;
      logic move_busy;
      logic out_free;
   } stat_type;

   // sign-extend the pushed word, keep the low cell bits
   function automatic logic [DATA_WIDTH-1:0] to_cell(input logic signed [IO_WIDTH-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[DATA_WIDTH-1:0];
   endfunction

   // sign-extend a cell word to the result width
   function automatic logic signed [IO_WIDTH-1:0] from_cell(input logic [DATA_WIDTH-1:0] d);
      logic signed [DATA_WIDTH-1:0] s;
      logic signed [63:0]           w;
      s = d;
      w = 64'(s);
      return w[IO_WIDTH-1:0];
   endfunction

endpackage

>>> hw/rtl/tsb_req_if.sv
// ----------------------------------------------------------------------------
// tsb_req_if
// request channel: push or pop on one of the three stacks
// ----------------------------------------------------------------------------
interface tsb_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     req_type;
   logic [1:0]                               stack_id;
   logic signed [tsb_pkg::IO_WIDTH-1:0]      push_value;

   modport source (output valid, output req_type, output stack_id, output push_value,
                   input ready);
   modport sink   (input valid, input req_type, input stack_id, input push_value,
                   output ready);
endinterface

>>> hw/rtl/tsb_rsp_if.sv
// ----------------------------------------------------------------------------
// tsb_rsp_if
// response channel: status and popped value
// ----------------------------------------------------------------------------
interface tsb_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [tsb_pkg::IO_WIDTH-1:0]      pop_value;
   logic [1:0]                               status;

   modport source (output valid, output pop_value, output status, input ready);
   modport sink   (input valid, input pop_value, input status, output ready);
endinterface

>>> hw/rtl/tsb_ram.sv
// ----------------------------------------------------------------------------
// tsb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// tsb_ctrl
// sequencer: accept, execute, and cell-by-cell relocation of the middle stack
// ----------------------------------------------------------------------------
module tsb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tsb_pkg::stat_type   stat,
   output tsb_pkg::cmd_type    cmd,
   output tsb_pkg::state_type  state
);

   tsb_pkg::state_type state_ff;
   tsb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsb_pkg::S_IDLE: begin
            if (req_valid) state_in = tsb_pkg::S_EXEC;
         end
         tsb_pkg::S_EXEC: begin
            if (stat.collide && !stat.blocked) state_in = tsb_pkg::S_MOVE_RD;
            else if (stat.out_free)            state_in = tsb_pkg::S_IDLE;
         end
         tsb_pkg::S_MOVE_RD: begin
            if (stat.move_busy) state_in = tsb_pkg::S_MOVE_WR;
            else                state_in = tsb_pkg::S_EXEC;
         end
         tsb_pkg::S_MOVE_WR: begin
            state_in = tsb_pkg::S_MOVE_RD;
         end
         default: state_in = tsb_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tsb_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         tsb_pkg::S_EXEC: begin
            if (stat.collide && !stat.blocked) cmd.start_move = 1'b1;
            else                               cmd.commit     = stat.out_free;
         end
         tsb_pkg::S_MOVE_RD: begin
            if (stat.move_busy) cmd.move_rd  = 1'b1;
            else                cmd.move_end = 1'b1;
         end
         tsb_pkg::S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

>>> hw/rtl/tsb_dp.sv
// ----------------------------------------------------------------------------
// tsb_dp
// stack pointers, request and response registers, shared cell memory
// ----------------------------------------------------------------------------
module tsb_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_type,
   input  logic [1:0]                          req_stack_id,
   input  logic signed [tsb_pkg::IO_WIDTH-1:0] req_push_value,
   tsb_rsp_if.source                           rsp_chan,
   input  tsb_pkg::cmd_type                    cmd,
   output tsb_pkg::stat_type                   stat
);

   localparam int PW = tsb_pkg::PTR_W;
   localparam int AW = tsb_pkg::ADDR_W;
   localparam int DW = tsb_pkg::DATA_WIDTH;

   // pointers: lc = left_top + 1, me = mid_top + 1, rt = right_top, mb = mid_base
   logic [PW-1:0] lc_ff, lc_in, mb_ff, mb_in, me_ff, me_in, rt_ff, rt_in;
   logic [PW-1:0] mv_ff, mv_in, dist_ff, dist_in;
   logic          up_ff, up_in;

   tsb_pkg::op_type       op_ff, op_in;
   tsb_pkg::stack_id_type id_ff, id_in;
   logic [DW-1:0]         val_ff, val_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [tsb_pkg::IO_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   tsb_pkg::status_type                 rsp_status_ff, rsp_status_in;

   logic [PW-1:0] gap, dist_calc, acc_ptr, push_ptr, src_ptr, dst_ptr;
   logic          is_bad, is_push, empty, push_ok, pop_ok;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [DW-1:0] ram_wr_data, ram_rd_data;

   tsb_ram #(.WIDTH(DW), .DEPTH(tsb_pkg::DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // decode of the held request
   always_comb begin
      is_bad  = (id_ff == tsb_pkg::ID_BAD);
      is_push = (op_ff == tsb_pkg::OP_PUSH);
      gap     = (id_ff == tsb_pkg::ID_LEFT) ? (rt_ff - me_ff) : (mb_ff - lc_ff);
      dist_calc = gap >> 1;
      unique case (id_ff)
         tsb_pkg::ID_LEFT:  empty = (lc_ff == '0);
         tsb_pkg::ID_MID:   empty = (me_ff == mb_ff);
         tsb_pkg::ID_RIGHT: empty = (rt_ff == tsb_pkg::PTR_DEPTH);
         default:           empty = 1'b0;
      endcase
      stat.collide = is_push && !is_bad &&
                     ((id_ff == tsb_pkg::ID_LEFT) ? (lc_ff == mb_ff) : (me_ff == rt_ff));
      stat.blocked   = stat.collide && (dist_calc == '0);
      stat.move_busy = up_ff ? (mv_ff > mb_ff) : (mv_ff < me_ff);
      stat.out_free  = !rsp_valid_ff || rsp_chan.ready;
      push_ok = is_push && !is_bad && !stat.collide;
      pop_ok  = !is_push && !is_bad && !empty;
   end

   // addresses
   always_comb begin
      unique case (tsb_pkg::stack_id_type'(req_stack_id))
         tsb_pkg::ID_LEFT: acc_ptr = lc_ff - tsb_pkg::PTR_ONE;
         tsb_pkg::ID_MID:  acc_ptr = me_ff - tsb_pkg::PTR_ONE;
         default:          acc_ptr = rt_ff;
      endcase
      unique case (id_ff)
         tsb_pkg::ID_LEFT: push_ptr = lc_ff;
         tsb_pkg::ID_MID:  push_ptr = me_ff;
         default:          push_ptr = rt_ff - tsb_pkg::PTR_ONE;
      endcase
      src_ptr = up_ff ? (mv_ff - tsb_pkg::PTR_ONE) : mv_ff;
      dst_ptr = up_ff ? (mv_ff - tsb_pkg::PTR_ONE + dist_ff) : (mv_ff - dist_ff);

      ram_rd_en   = cmd.accept || cmd.move_rd;
      ram_rd_addr = cmd.move_rd ? src_ptr[AW-1:0] : acc_ptr[AW-1:0];
      ram_wr_en   = cmd.move_wr || (cmd.commit && push_ok);
      ram_wr_addr = cmd.move_wr ? dst_ptr[AW-1:0] : push_ptr[AW-1:0];
      ram_wr_data = cmd.move_wr ? ram_rd_data : val_ff;
   end

   // next values
   always_comb begin
      lc_in = lc_ff;  mb_in = mb_ff;  me_in = me_ff;  rt_in = rt_ff;
      mv_in = mv_ff;  dist_in = dist_ff;  up_in = up_ff;
      op_in = op_ff;  id_in = id_ff;  val_in = val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.accept) begin
         op_in  = tsb_pkg::op_type'(req_type);
         id_in  = tsb_pkg::stack_id_type'(req_stack_id);
         val_in = tsb_pkg::to_cell(req_push_value);
      end
      if (cmd.start_move) begin
         up_in   = (id_ff == tsb_pkg::ID_LEFT);
         dist_in = dist_calc;
         mv_in   = (id_ff == tsb_pkg::ID_LEFT) ? me_ff : mb_ff;
      end
      if (cmd.move_wr) begin
         mv_in = up_ff ? (mv_ff - tsb_pkg::PTR_ONE) : (mv_ff + tsb_pkg::PTR_ONE);
      end
      if (cmd.move_end) begin
         mb_in = up_ff ? (mb_ff + dist_ff) : (mb_ff - dist_ff);
         me_in = up_ff ? (me_ff + dist_ff) : (me_ff - dist_ff);
      end
      if (cmd.commit) begin
         priority if (push_ok) begin
            unique case (id_ff)
               tsb_pkg::ID_LEFT: lc_in = lc_ff + tsb_pkg::PTR_ONE;
               tsb_pkg::ID_MID:  me_in = me_ff + tsb_pkg::PTR_ONE;
               default:          rt_in = rt_ff - tsb_pkg::PTR_ONE;
            endcase
         end else if (pop_ok) begin
            unique case (id_ff)
               tsb_pkg::ID_LEFT: lc_in = lc_ff - tsb_pkg::PTR_ONE;
               tsb_pkg::ID_MID:  me_in = me_ff - tsb_pkg::PTR_ONE;
               default:          rt_in = rt_ff + tsb_pkg::PTR_ONE;
            endcase
         end
         rsp_valid_in = 1'b1;
         rsp_value_in = pop_ok ? tsb_pkg::from_cell(ram_rd_data) : '0;
         priority if (is_bad)       rsp_status_in = tsb_pkg::ST_BADID;
         else if (is_push && stat.blocked) rsp_status_in = tsb_pkg::ST_FULL;
         else if (!is_push && empty)       rsp_status_in = tsb_pkg::ST_EMPTY;
         else                              rsp_status_in = tsb_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff        <= '0;
         mb_ff        <= tsb_pkg::PTR_HALF;
         me_ff        <= tsb_pkg::PTR_HALF;
         rt_ff        <= tsb_pkg::PTR_DEPTH;
         rsp_valid_ff <= 1'b0;
      end else begin
         lc_ff        <= lc_in;
         mb_ff        <= mb_in;
         me_ff        <= me_in;
         rt_ff        <= rt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_ff         <= mv_in;
      dist_ff       <= dist_in;
      up_ff         <= up_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      val_ff        <= val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pop_value = rsp_value_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule

>>> hw/rtl/three_stacks_shared_buffer_top.sv
// a result is registered by the execute step that follows its accept (read issued at accept)
// a new item is taken only once the sequencer is back in idle after the last execute step
// a push that meets the middle stack first relocates the middle cells, with each moved
// cell taking a read step and then a write step (registered read data)
// reset (synchronous, active high): all stacks empty, middle stack based at the centre,
// cell contents are left as they were and a cell's value is never used before being written
// ----------------------------------------------------------------------------
// three_stacks_shared_buffer_top
// three stacks (left up, right down, middle up from the centre) in one memory
// ----------------------------------------------------------------------------
module three_stacks_shared_buffer_top (
   input  logic      clock,
   input  logic      reset,
   tsb_req_if.sink   req_chan,
   tsb_rsp_if.source rsp_chan
);

   // command and status between sequencer and datapath
   tsb_pkg::cmd_type   cmd;
   tsb_pkg::stat_type  stat;
   tsb_pkg::state_type state;
   logic               req_ready;

   // sequencer: idle -> execute, with an optional read/write loop that slides
   // the middle stack by half the free gap before the colliding push
   tsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd),
      .state     (state)
   );

   // datapath: pointers, cell memory and the response register, which lets a
   // new item come in while the previous result still waits for its taker
   tsb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_chan.req_type),
      .req_stack_id   (req_chan.stack_id),
      .req_push_value (req_chan.push_value),
      .rsp_chan       (rsp_chan),
      .cmd            (cmd),
      .stat           (stat)
   );

   assign req_chan.ready = req_ready;

   // an accepted item always goes straight to execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state == tsb_pkg::S_EXEC))
      else $error("accepted item did not move to execute");

   // a fresh result only appears right after the execute step
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !$past(rsp_chan.valid)) |-> ($past(state) == tsb_pkg::S_EXEC))
      else $error("result raised outside execute");

   // a blocked shift must never start a relocation
   a_blocked_no_move: assert property (@(posedge clock) disable iff (reset)
      (state == tsb_pkg::S_EXEC && stat.blocked) |=> (state != tsb_pkg::S_MOVE_RD))
      else $error("relocation started on a blocked push");

   // the move loop always returns to execute once the middle stack is relocated
   a_move_end: assert property (@(posedge clock) disable iff (reset)
      (state == tsb_pkg::S_MOVE_RD && !stat.move_busy) |=> (state == tsb_pkg::S_EXEC))
      else $error("relocation did not return to execute");

endmodule

>>> verif/three_stacks_shared_buffer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_stacks_shared_buffer_top_test
// self-checking bench for the three stack shared buffer: a queued driver,
// a checking monitor, a behavioural copy of the stacks and random back-pressure
// ----------------------------------------------------------------------------
module three_stacks_shared_buffer_top_test;

   localparam int RANDOM_ITEMS = 1730;
   localparam int IDLE_PCT     = 18;
   localparam int CALM_FIRST   = 2000;    // window with no gaps on either side
   localparam int CALM_LAST    = 3400;
   localparam int HOLD_START   = 1200;    // long receiver stall starts here
   localparam int HOLD_LEN     = 250;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      tsb_pkg::op_type                     op;
      tsb_pkg::stack_id_type               sid;
      logic signed [tsb_pkg::IO_WIDTH-1:0] value;
   } stack_req_type;

   typedef struct {
      logic signed [tsb_pkg::IO_WIDTH-1:0] pop_value;
      tsb_pkg::status_type                 status;
   } stack_rsp_type;

   logic clock;
   logic reset;

   tsb_req_if req_bus ();
   tsb_rsp_if rsp_bus ();

   three_stacks_shared_buffer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // items waiting to be offered, and results still owed by the block
   stack_req_type pending_reqs [$];
   stack_rsp_type awaited_rsps [$];

   // shadow copy of the shared memory and its four pointers
   logic [tsb_pkg::DATA_WIDTH-1:0] shadow_cells [tsb_pkg::DEPTH];
   int left_top;
   int right_top;
   int mid_base;
   int mid_top;

   int cycle_count    = 0;
   int hold_cycles    = 0;
   int items_accepted = 0;
   int total_items    = 0;
   int directed_items = 0;
   int error_count    = 0;

   // what the run went through
   int pushes_stored  = 0;
   int pops_returned  = 0;
   int full_refusals  = 0;
   int empty_pops     = 0;
   int bad_ids        = 0;
   int middle_moves   = 0;

   stack_req_type in_flight;
   stack_rsp_type oldest;

   logic calm_window;
   assign calm_window = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

   // ------------------------------------------------------------------------
   // stack behaviour
   // ------------------------------------------------------------------------

   // slide the middle stack by shift_by cells, copying from the far end first
   function automatic void shift_middle(int shift_by);
      int k;
      if (shift_by > 0) begin
         for (k = mid_top; k >= mid_base; k--)
            shadow_cells[k + shift_by] = shadow_cells[k];
      end else begin
         for (k = mid_base; k <= mid_top; k++)
            shadow_cells[k + shift_by] = shadow_cells[k];
      end
      mid_base += shift_by;
      mid_top  += shift_by;
      middle_moves++;
   endfunction

   // apply one request to the shadow stacks and return the result it owes
   function automatic stack_rsp_type apply_to_stacks(stack_req_type r);
      stack_rsp_type                  rsp;
      logic [tsb_pkg::DATA_WIDTH-1:0] word;
      logic signed [63:0]             wide;
      int                             shift_by;
      rsp.pop_value = '0;
      rsp.status    = tsb_pkg::ST_OK;
      wide = 64'(r.value);
      word = wide[tsb_pkg::DATA_WIDTH-1:0];
      if (r.sid == tsb_pkg::ID_BAD) begin
         rsp.status = tsb_pkg::ST_BADID;
      end else if (r.op == tsb_pkg::OP_PUSH) begin
         if (r.sid == tsb_pkg::ID_LEFT) begin
            // left meets the middle: middle moves up by half the gap above it
            if (left_top + 1 == mid_base) begin
               shift_by = (right_top - mid_top - 1) / 2;
               if (shift_by <= 0) rsp.status = tsb_pkg::ST_FULL;
               else shift_middle(shift_by);
            end
            if (rsp.status == tsb_pkg::ST_OK) begin
               left_top++;
               shadow_cells[left_top] = word;
            end
         end else begin
            // middle meets the right: middle moves down by half the gap below it
            if (mid_top + 1 == right_top) begin
               shift_by = -((mid_base - left_top - 1) / 2);
               if (shift_by >= 0) rsp.status = tsb_pkg::ST_FULL;
               else shift_middle(shift_by);
            end
            if (rsp.status == tsb_pkg::ST_OK) begin
               if (r.sid == tsb_pkg::ID_MID) begin
                  mid_top++;
                  shadow_cells[mid_top] = word;
               end else begin
                  right_top--;
                  shadow_cells[right_top] = word;
               end
            end
         end
      end else begin
         case (r.sid)
            tsb_pkg::ID_LEFT: begin
               if (left_top < 0) rsp.status = tsb_pkg::ST_EMPTY;
               else begin
                  word = shadow_cells[left_top];
                  left_top--;
               end
            end
            tsb_pkg::ID_MID: begin
               if (mid_top < mid_base) rsp.status = tsb_pkg::ST_EMPTY;
               else begin
                  word = shadow_cells[mid_top];
                  mid_top--;
               end
            end
            default: begin
               if (right_top >= tsb_pkg::DEPTH) rsp.status = tsb_pkg::ST_EMPTY;
               else begin
                  word = shadow_cells[right_top];
                  right_top++;
               end
            end
         endcase
         if (rsp.status == tsb_pkg::ST_OK) begin
            wide = 64'(signed'(word));
            rsp.pop_value = wide[tsb_pkg::IO_WIDTH-1:0];
         end
      end
      case (rsp.status)
         tsb_pkg::ST_OK:    if (r.op == tsb_pkg::OP_PUSH) pushes_stored++; else pops_returned++;
         tsb_pkg::ST_FULL:  full_refusals++;
         tsb_pkg::ST_EMPTY: empty_pops++;
         default:           bad_ids++;
      endcase
      return rsp;
   endfunction

   function automatic void queue_req(tsb_pkg::op_type op, tsb_pkg::stack_id_type sid,
                                     logic signed [tsb_pkg::IO_WIDTH-1:0] value);
      stack_req_type r;
      r.op    = op;
      r.sid   = sid;
      r.value = value;
      pending_reqs.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // clock, cycle count and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d items accepted, %0d results owed",
                  cycle_count, items_accepted, total_items, awaited_rsps.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // driver: offers queued items, feeds the shadow stacks on each accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.req_type   <= tsb_pkg::OP_PUSH;
         req_bus.stack_id   <= tsb_pkg::ID_LEFT;
         req_bus.push_value <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_rsps.push_back(apply_to_stacks(in_flight));
            items_accepted++;
         end
         // the slot is free once the current item has gone, or if none is held
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() != 0 &&
                (calm_window || $urandom_range(99) >= IDLE_PCT)) begin
               in_flight = pending_reqs.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= in_flight.op;
               req_bus.stack_id   <= in_flight.sid;
               req_bus.push_value <= in_flight.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver hold-off: one long stall while the sender keeps offering
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (cycle_count == HOLD_START) begin
         hold_cycles <= HOLD_LEN;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks each result against the oldest one owed
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsps.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("cycle %0d: result with nothing owed, pop_value %h status %0d",
                           cycle_count, rsp_bus.pop_value, rsp_bus.status);
            end else begin
               oldest = awaited_rsps.pop_front();
               if (rsp_bus.pop_value !== oldest.pop_value ||
                   rsp_bus.status !== oldest.status) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("cycle %0d: pop_value exp %h got %h, status exp %0d got %0d",
                              cycle_count, oldest.pop_value, rsp_bus.pop_value,
                              oldest.status, rsp_bus.status);
               end
            end
         end
         if (hold_cycles != 0)
            rsp_bus.ready <= 1'b0;
         else
            rsp_bus.ready <= calm_window || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int            remaining;
      int            phase_len;
      int            push_pct;
      int            favour;
      int            i;
      stack_req_type r;

      reset <= 1'b1;

      // shadow state after reset: all empty, middle based at the centre
      left_top  = -1;
      right_top = tsb_pkg::DEPTH;
      mid_base  = tsb_pkg::DEPTH / 2;
      mid_top   = mid_base - 1;

      // directed: empty pops, bad id both ways, value extremes on every stack
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_LEFT,  32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_MID,   32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_RIGHT, 32'sd0);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_BAD,   32'sh1234_5678);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_BAD,   -32'sd1);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_LEFT,  32'sh7fff_ffff);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_MID,   32'sh8000_0000);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_RIGHT, -32'sd1);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_LEFT,  32'sd0);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_MID,   32'sh5555_5555);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_RIGHT, 32'shaaaa_aaaa);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_RIGHT, 32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_MID,   -32'sd1);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_LEFT,  32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_LEFT,  32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_MID,   32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_RIGHT, 32'sd0);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_RIGHT, 32'sd0);
      queue_req(tsb_pkg::OP_PUSH, tsb_pkg::ID_RIGHT, 32'sd1);
      queue_req(tsb_pkg::OP_POP,  tsb_pkg::ID_RIGHT, 32'sd0);
      directed_items = pending_reqs.size();

      // random: phases that fill, drain or mix, often leaning on one stack,
      // so the middle stack is pushed around and the memory runs full
      remaining = RANDOM_ITEMS;
      while (remaining > 0) begin
         phase_len = $urandom_range(90, 15);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         favour = $urandom_range(3);
         for (i = 0; i < phase_len && remaining > 0; i++) begin
            r.op = ($urandom_range(99) < push_pct) ? tsb_pkg::OP_PUSH : tsb_pkg::OP_POP;
            if ($urandom_range(99) < 4)
               r.sid = tsb_pkg::ID_BAD;
            else if (favour != 3 && $urandom_range(99) < 60)
               r.sid = tsb_pkg::stack_id_type'(favour);
            else
               r.sid = tsb_pkg::stack_id_type'($urandom_range(2));
            case ($urandom_range(9))
               0:       r.value = 32'sd0;
               1:       r.value = -32'sd1;
               2:       r.value = 32'sh7fff_ffff;
               3:       r.value = 32'sh8000_0000;
               default: r.value = $urandom;
            endcase
            pending_reqs.push_back(r);
            remaining--;
         end
      end
      total_items = pending_reqs.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != total_items) @(posedge clock);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items (%0d directed): %0d pushes stored, %0d pops returned",
               total_items, directed_items, pushes_stored, pops_returned);
      $display("  %0d refused as full, %0d empty pops, %0d bad ids, %0d middle moves",
               full_refusals, empty_pops, bad_ids, middle_moves);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
